// ===== src/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; imported by poly_voice_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    localparam int MAX_VOICES = 16;
    localparam int HELD_DEPTH = 16;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
    localparam logic [6:0] NOTE_TOP = 7'd127;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
    } pva_in_t;

    typedef struct packed {
        logic [3:0] voice_index;
        logic [6:0] voice_note;
        logic [6:0] voice_velocity;
        logic       voice_gate;
        logic       last_voice;
    } pva_out_t;

    typedef struct packed {
        logic [6:0] note;
        logic [6:0] vel;
    } pva_entry_t;

endpackage

`default_nettype wire

// ===== src/poly_voice_allocator_core.sv =====
// Round-robin polyphonic voice allocator driven by MIDI channel messages.
// Depends on pva_pkg for payload types and message constants.
`timescale 1ns / 1ps
`default_nettype none

// One message is taken at a time and answered with one beat per active
// voice. Voice note/velocity sit in a single-port synchronous memory and the
// held-key stack in a synchronous memory with separate read and write
// addresses; every held-key access is a read state followed by a check or
// write state, and an all-notes-off or all-sound-off repeats the note-off
// for all 128 notes. A new message is taken as soon as the last voice beat
// sits in the output register.
module poly_voice_allocator_core
    import pva_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire pva_in_t    s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output pva_out_t        m_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [4:0] cfg_wr_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_H_RD   = 4'd1;
    localparam logic [3:0] ST_H_CK   = 4'd2;
    localparam logic [3:0] ST_SH_RD  = 4'd3;
    localparam logic [3:0] ST_SH_WR  = 4'd4;
    localparam logic [3:0] ST_V_SCAN = 4'd5;
    localparam logic [3:0] ST_RS_RD  = 4'd6;
    localparam logic [3:0] ST_RS_CK  = 4'd7;
    localparam logic [3:0] ST_PICK   = 4'd8;
    localparam logic [3:0] ST_REP_RD = 4'd9;
    localparam logic [3:0] ST_REP_OUT = 4'd10;

    logic [3:0]  state_reg;
    logic        op_on_reg;
    logic        aoff_reg;
    logic [6:0]  note_reg;
    logic [6:0]  vel_reg;
    logic [4:0]  hi_reg;
    logic [4:0]  hcnt_reg;
    logic [3:0]  vc_reg;
    logic [4:0]  step_reg;
    logic [3:0]  ptr_reg;
    logic [4:0]  vcount_reg;
    logic [15:0] gate_reg;
    logic [15:0] vvld_reg;
    logic [6:0]  shadow_reg [MAX_VOICES];

    // Voice memory and held-key memory.
    pva_entry_t  vmem [MAX_VOICES];
    pva_entry_t  hmem [HELD_DEPTH];
    pva_entry_t  vrd_reg;
    logic        vrd_vld_reg;
    pva_entry_t  hrd_reg;

    logic        v_we;
    pva_entry_t  v_wdata;
    logic        h_we;
    logic [3:0]  h_waddr;
    pva_entry_t  h_wdata;
    logic [3:0]  h_raddr;

    logic [4:0]  vc_inc;
    logic        vc_last;
    logic [3:0]  vc_wrap;
    logic [3:0]  pick_wrap;
    logic        sounding;
    logic [4:0]  cfg_n;
    logic [3:0]  kind;
    logic        out_free;

    assign kind     = s_data.status_byte[7:4];
    assign vc_inc   = {1'b0, vc_reg} + 5'd1;
    assign vc_last  = (vc_inc == vcount_reg);
    assign vc_wrap  = vc_last ? 4'd0 : vc_inc[3:0];
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid || m_ready;

    always_comb begin
        if (cfg_wr_data == 5'd0) begin
            cfg_n = 5'd1;
        end else if (cfg_wr_data > 5'd16) begin
            cfg_n = 5'd16;
        end else begin
            cfg_n = cfg_wr_data;
        end
    end

    // A held key counts as sounding if any active gated voice plays it.
    always_comb begin
        sounding = 1'b0;
        for (int c = 0; c < MAX_VOICES; c++) begin
            if ((5'(c) < vcount_reg) && gate_reg[c] && (shadow_reg[c] == hrd_reg.note)) begin
                sounding = 1'b1;
            end
        end
    end

    always_comb begin
        pick_wrap = vc_wrap;
        h_raddr   = (state_reg == ST_SH_RD) ? 4'(hi_reg + 5'd1) : hi_reg[3:0];
        h_we      = 1'b0;
        h_waddr   = hi_reg[3:0];
        h_wdata   = '{note: note_reg, vel: vel_reg};
        v_we      = 1'b0;
        v_wdata   = '{note: note_reg, vel: vel_reg};
        case (state_reg)
            ST_IDLE: begin
                // A note-on into an empty stack lands in the bottom entry right away.
                if (s_valid && kind == KIND_NOTE_ON && s_data.data_two != 7'd0
                    && hcnt_reg == 5'd0) begin
                    h_we    = 1'b1;
                    h_waddr = 4'd0;
                    h_wdata = '{note: s_data.data_one, vel: s_data.data_two};
                end
            end
            ST_H_CK: begin
                if (op_on_reg) begin
                    if (hrd_reg.note == note_reg) begin
                        h_we = 1'b1;
                    end else if ((hi_reg + 5'd1 >= hcnt_reg) && (hcnt_reg < 5'd16)) begin
                        h_we    = 1'b1;
                        h_waddr = hcnt_reg[3:0];
                    end
                end
            end
            ST_SH_WR: begin
                h_we    = 1'b1;
                h_wdata = hrd_reg;
            end
            ST_RS_CK: begin
                v_we    = !sounding;
                v_wdata = hrd_reg;
            end
            ST_PICK: begin
                v_we = !gate_reg[vc_reg] || (step_reg == vcount_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (v_we) begin
            vmem[vc_reg] <= v_wdata;
        end
        vrd_reg     <= vmem[vc_reg];
        vrd_vld_reg <= vvld_reg[vc_reg];
        if (h_we) begin
            hmem[h_waddr] <= h_wdata;
        end
        hrd_reg <= hmem[h_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            op_on_reg  <= 1'b0;
            aoff_reg   <= 1'b0;
            hcnt_reg   <= '0;
            hi_reg     <= '0;
            vc_reg     <= '0;
            step_reg   <= '0;
            ptr_reg    <= '0;
            vcount_reg <= 5'd16;
            gate_reg   <= '0;
            vvld_reg   <= '0;
            m_valid    <= 1'b0;
            for (int c = 0; c < MAX_VOICES; c++) begin
                shadow_reg[c] <= '0;
            end
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            if (cfg_wr_en) begin
                vcount_reg <= cfg_n;
                if ({1'b0, ptr_reg} >= cfg_n) begin
                    ptr_reg <= '0;
                end
                for (int c = 0; c < MAX_VOICES; c++) begin
                    if (5'(c) >= cfg_n) begin
                        shadow_reg[c] <= '0;
                        gate_reg[c]   <= 1'b0;
                        vvld_reg[c]   <= 1'b0;
                    end
                end
            end
            if (v_we) begin
                shadow_reg[vc_reg] <= v_wdata.note;
                gate_reg[vc_reg]   <= 1'b1;
                vvld_reg[vc_reg]   <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        note_reg  <= s_data.data_one;
                        vel_reg   <= s_data.data_two;
                        hi_reg    <= '0;
                        vc_reg    <= '0;
                        aoff_reg  <= 1'b0;
                        op_on_reg <= 1'b0;
                        if (kind == KIND_NOTE_ON && s_data.data_two != 7'd0) begin
                            op_on_reg <= 1'b1;
                            if (hcnt_reg == 5'd0) begin
                                // Empty stack: push directly and go pick a voice.
                                hcnt_reg <= 5'd1;
                                state_reg <= ST_PICK;
                                vc_reg    <= ptr_reg;
                                step_reg  <= '0;
                            end else begin
                                state_reg <= ST_H_RD;
                            end
                        end else if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
                            state_reg <= (hcnt_reg == 5'd0) ? ST_V_SCAN : ST_H_RD;
                        end else if (kind == KIND_CTRL && (s_data.data_one == CC_ALL_SOUND_OFF
                                     || s_data.data_one == CC_ALL_NOTES_OFF)) begin
                            aoff_reg  <= 1'b1;
                            note_reg  <= '0;
                            state_reg <= (hcnt_reg == 5'd0) ? ST_V_SCAN : ST_H_RD;
                        end else begin
                            state_reg <= ST_REP_RD;
                        end
                    end
                end
                ST_H_RD: begin
                    state_reg <= ST_H_CK;
                end
                ST_H_CK: begin
                    if (hrd_reg.note == note_reg) begin
                        if (op_on_reg) begin
                            state_reg <= ST_PICK;
                            vc_reg    <= ptr_reg;
                            step_reg  <= '0;
                        end else if (hi_reg + 5'd1 < hcnt_reg) begin
                            state_reg <= ST_SH_RD;
                        end else begin
                            hcnt_reg  <= hcnt_reg - 5'd1;
                            vc_reg    <= '0;
                            state_reg <= ST_V_SCAN;
                        end
                    end else if (hi_reg + 5'd1 < hcnt_reg) begin
                        hi_reg    <= hi_reg + 5'd1;
                        state_reg <= ST_H_RD;
                    end else if (op_on_reg) begin
                        if (hcnt_reg < 5'd16) begin
                            hcnt_reg <= hcnt_reg + 5'd1;
                        end
                        state_reg <= ST_PICK;
                        vc_reg    <= ptr_reg;
                        step_reg  <= '0;
                    end else begin
                        vc_reg    <= '0;
                        state_reg <= ST_V_SCAN;
                    end
                end
                ST_SH_RD: begin
                    state_reg <= ST_SH_WR;
                end
                ST_SH_WR: begin
                    hi_reg <= hi_reg + 5'd1;
                    if (hi_reg + 5'd2 < hcnt_reg) begin
                        state_reg <= ST_SH_RD;
                    end else begin
                        hcnt_reg  <= hcnt_reg - 5'd1;
                        vc_reg    <= '0;
                        state_reg <= ST_V_SCAN;
                    end
                end
                ST_V_SCAN, ST_RS_CK: begin
                    if (state_reg == ST_V_SCAN && shadow_reg[vc_reg] == note_reg
                        && gate_reg[vc_reg] && hcnt_reg != 5'd0) begin
                        // Freed voice: search the stack from the newest key down.
                        gate_reg[vc_reg] <= 1'b0;
                        hi_reg    <= hcnt_reg - 5'd1;
                        state_reg <= ST_RS_RD;
                    end else if (state_reg == ST_RS_CK && sounding && hi_reg != 5'd0) begin
                        hi_reg    <= hi_reg - 5'd1;
                        state_reg <= ST_RS_RD;
                    end else begin
                        if (state_reg == ST_V_SCAN && shadow_reg[vc_reg] == note_reg) begin
                            gate_reg[vc_reg] <= 1'b0;
                        end
                        if (!vc_last) begin
                            vc_reg    <= vc_wrap;
                            state_reg <= ST_V_SCAN;
                        end else if (aoff_reg && note_reg != NOTE_TOP) begin
                            note_reg  <= note_reg + 7'd1;
                            hi_reg    <= '0;
                            vc_reg    <= '0;
                            state_reg <= (hcnt_reg == 5'd0) ? ST_V_SCAN : ST_H_RD;
                        end else begin
                            vc_reg    <= '0;
                            state_reg <= ST_REP_RD;
                        end
                    end
                end
                ST_RS_RD: begin
                    state_reg <= ST_RS_CK;
                end
                ST_PICK: begin
                    // After a full lap with every voice sounding, vc_reg is back at
                    // the pointer and that voice is stolen.
                    if (!gate_reg[vc_reg] || step_reg == vcount_reg) begin
                        ptr_reg   <= pick_wrap;
                        vc_reg    <= '0;
                        state_reg <= ST_REP_RD;
                    end else begin
                        vc_reg   <= vc_wrap;
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_REP_RD: begin
                    state_reg <= ST_REP_OUT;
                end
                ST_REP_OUT: begin
                    if (out_free) begin
                        m_valid <= 1'b1;
                        if (vc_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            vc_reg    <= vc_wrap;
                            state_reg <= ST_REP_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_REP_OUT && out_free) begin
            m_data.voice_index    <= vc_reg;
            m_data.voice_note     <= vrd_vld_reg ? vrd_reg.note : 7'd0;
            m_data.voice_velocity <= vrd_vld_reg ? vrd_reg.vel : 7'd0;
            m_data.voice_gate     <= gate_reg[vc_reg];
            m_data.last_voice     <= vc_last;
        end
    end

endmodule

`default_nettype wire
